[sv/rmq_pkg.sv]
`default_nettype none
package rmq_pkg;
   localparam int LANES = 4;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;
   localparam int LANE_W = 3;
   typedef logic [LANES-1:0] lane_mask_type;
endpackage
`default_nettype wire

[sv/rotation_matrix_to_quaternion_top.sv]
`default_nettype none
// Rotation matrix to unit quaternion.
// Input channel: drive the nine matrix elements on req_r00..req_r22 (signed Q2.F,
// F = WORD_BITS - 2) and raise start; a beat is taken at every rising edge with
// start high and busy low. busy stays low, so a new matrix can enter every cycle.
// Result channel: rsp_strobe is high for one cycle with rsp_qx, rsp_qy, rsp_qz,
// rsp_qw and rsp_valid_res; the receiver takes it at that edge and cannot stall.
// rsp_valid_res is 0, with all components 0, when the pivot is not positive.
// Stages in order: branch and pivot, square-root pipeline (one root bit a stage),
// divisor setup (the rounding term is folded into the numerator), four-lane divider
// pipeline (one quotient bit a stage), and saturation into the output registers.
// Throughput: one matrix per cycle, set by the fully pipelined root and divider.
// Reset clears every stage valid bit; beats in flight are dropped and no strobe
// follows until new beats arrive.
module rotation_matrix_to_quaternion_top #(
   parameter int WORD_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [WORD_BITS-1:0] req_r00,
   input  wire logic signed [WORD_BITS-1:0] req_r01,
   input  wire logic signed [WORD_BITS-1:0] req_r02,
   input  wire logic signed [WORD_BITS-1:0] req_r10,
   input  wire logic signed [WORD_BITS-1:0] req_r11,
   input  wire logic signed [WORD_BITS-1:0] req_r12,
   input  wire logic signed [WORD_BITS-1:0] req_r20,
   input  wire logic signed [WORD_BITS-1:0] req_r21,
   input  wire logic signed [WORD_BITS-1:0] req_r22,
   output logic                             rsp_strobe,
   output logic signed [WORD_BITS-1:0]      rsp_qx,
   output logic signed [WORD_BITS-1:0]      rsp_qy,
   output logic signed [WORD_BITS-1:0]      rsp_qz,
   output logic signed [WORD_BITS-1:0]      rsp_qw,
   output logic                             rsp_valid_res
);
   import rmq_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = W - 2;
   localparam int TW = W + 2;
   localparam int NW = 2 * W;
   localparam int RW = W + 2;
   localparam int DW = W + 1;
   localparam int UW = TW + F + 1;

   // front stage
   logic                 v0_ff;
   logic signed [TW-1:0] t0_ff, t0_in;
   logic signed [TW-1:0] c0_ff [0:LANES-1];
   logic signed [TW-1:0] c0_in [0:LANES-1];

   logic signed [TW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, one;

   assign busy = 1'b0;

   always_comb begin
      e00 = TW'(req_r00);
      e01 = TW'(req_r01);
      e02 = TW'(req_r02);
      e10 = TW'(req_r10);
      e11 = TW'(req_r11);
      e12 = TW'(req_r12);
      e20 = TW'(req_r20);
      e21 = TW'(req_r21);
      e22 = TW'(req_r22);
      one = TW'(1) <<< F;
      if (req_r22 < 0) begin
         if (req_r00 > req_r11) begin
            t0_in = one + e00 - e11 - e22;
            c0_in[LANE_X] = t0_in;
            c0_in[LANE_Y] = e01 + e10;
            c0_in[LANE_Z] = e20 + e02;
            c0_in[LANE_W] = e12 - e21;
         end else begin
            t0_in = one - e00 + e11 - e22;
            c0_in[LANE_X] = e01 + e10;
            c0_in[LANE_Y] = t0_in;
            c0_in[LANE_Z] = e12 + e21;
            c0_in[LANE_W] = e20 - e02;
         end
      end else begin
         if ((e00 + e11) < 0) begin
            t0_in = one - e00 - e11 + e22;
            c0_in[LANE_X] = e20 + e02;
            c0_in[LANE_Y] = e12 - e21;
            c0_in[LANE_Z] = t0_in;
            c0_in[LANE_W] = e01 + e10;
         end else begin
            t0_in = one + e00 + e11 + e22;
            c0_in[LANE_X] = e12 - e21;
            c0_in[LANE_Y] = e20 + e02;
            c0_in[LANE_Z] = e01 + e10;
            c0_in[LANE_W] = t0_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
      t0_ff <= t0_in;
      for (int l = 0; l < LANES; l++) begin
         c0_ff[l] <= c0_in[l];
      end
   end

   // square-root pipeline, one root bit per stage
   logic                 sv_ff   [0:W-1];
   logic                 spos_ff [0:W-1];
   logic [RW-1:0]        srem_ff [0:W-1];
   logic [W-1:0]         sroot_ff[0:W-1];
   logic [NW-1:0]        sn_ff   [0:W-1];
   logic signed [TW-1:0] sc_ff   [0:W-1][0:LANES-1];

   logic                 sv_cur  [0:W-1];
   logic                 spos_cur[0:W-1];
   logic [RW-1:0]        srem_cur[0:W-1];
   logic [W-1:0]         sroot_cur[0:W-1];
   logic [NW-1:0]        sn_cur  [0:W-1];
   logic signed [TW-1:0] sc_cur  [0:W-1][0:LANES-1];
   logic [RW-1:0]        srem_in [0:W-1];
   logic [W-1:0]         sroot_in[0:W-1];
   logic [RW-1:0]        sr2     [0:W-1];
   logic [RW-1:0]        strial  [0:W-1];

   always_comb begin
      sv_cur[0]    = v0_ff;
      spos_cur[0]  = (t0_ff > 0);
      srem_cur[0]  = '0;
      sroot_cur[0] = '0;
      sn_cur[0]    = NW'({{(NW-TW){1'b0}}, t0_ff} << F);
      for (int l = 0; l < LANES; l++) begin
         sc_cur[0][l] = c0_ff[l];
      end
      for (int k = 1; k < W; k++) begin
         sv_cur[k]    = sv_ff[k-1];
         spos_cur[k]  = spos_ff[k-1];
         srem_cur[k]  = srem_ff[k-1];
         sroot_cur[k] = sroot_ff[k-1];
         sn_cur[k]    = sn_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            sc_cur[k][l] = sc_ff[k-1][l];
         end
      end
      for (int k = 0; k < W; k++) begin
         sr2[k]    = {srem_cur[k][RW-3:0], sn_cur[k][NW-1:NW-2]};
         strial[k] = {sroot_cur[k], 2'b01};
         if (sr2[k] >= strial[k]) begin
            srem_in[k]  = sr2[k] - strial[k];
            sroot_in[k] = {sroot_cur[k][W-2:0], 1'b1};
         end else begin
            srem_in[k]  = sr2[k];
            sroot_in[k] = {sroot_cur[k][W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < W; k++) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else begin
            sv_ff[k] <= sv_cur[k];
         end
         spos_ff[k]  <= spos_cur[k];
         srem_ff[k]  <= srem_in[k];
         sroot_ff[k] <= sroot_in[k];
         sn_ff[k]    <= sn_cur[k] << 2;
         for (int l = 0; l < LANES; l++) begin
            sc_ff[k][l] <= sc_cur[k][l];
         end
      end
   end

   // divisor setup
   logic                 uv_ff, upos_ff;
   logic [DW-1:0]        ud_ff;
   lane_mask_type        uneg_ff, uovf_ff, uneg_in, uovf_in;
   logic [DW-1:0]        urem_ff [0:LANES-1];
   logic [DW-1:0]        ulow_ff [0:LANES-1];
   logic [DW-1:0]        urem_in [0:LANES-1];
   logic [DW-1:0]        ulow_in [0:LANES-1];
   logic [TW-1:0]        umag    [0:LANES-1];
   logic [UW-1:0]        unum    [0:LANES-1];
   logic [DW-1:0]        ud_in;
   logic [W-1:0]         uroot;

   always_comb begin
      uroot = sroot_ff[W-1];
      ud_in = {uroot, 1'b0};
      for (int l = 0; l < LANES; l++) begin
         uneg_in[l] = sc_ff[W-1][l][TW-1];
         umag[l]    = uneg_in[l] ? TW'(-sc_ff[W-1][l]) : TW'(sc_ff[W-1][l]);
         unum[l]    = UW'({{(UW-TW){1'b0}}, umag[l]} << F) + UW'(uroot);
         uovf_in[l] = (unum[l] >> DW) >= UW'(ud_in);
         urem_in[l] = uovf_in[l] ? '0 : DW'(unum[l] >> DW);
         ulow_in[l] = unum[l][DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_ff <= 1'b0;
      end else begin
         uv_ff <= sv_ff[W-1];
      end
      upos_ff <= spos_ff[W-1];
      ud_ff   <= ud_in;
      uneg_ff <= uneg_in;
      uovf_ff <= uovf_in;
      for (int l = 0; l < LANES; l++) begin
         urem_ff[l] <= urem_in[l];
         ulow_ff[l] <= ulow_in[l];
      end
   end

   // divider pipeline, one quotient bit per stage
   logic                 dv_ff   [0:DW-1];
   logic                 dpos_ff [0:DW-1];
   logic [DW-1:0]        dd_ff   [0:DW-1];
   lane_mask_type        dneg_ff [0:DW-1];
   lane_mask_type        dovf_ff [0:DW-1];
   logic [DW-1:0]        drem_ff [0:DW-1][0:LANES-1];
   logic [DW-1:0]        dlow_ff [0:DW-1][0:LANES-1];
   logic [DW-1:0]        dq_ff   [0:DW-1][0:LANES-1];

   logic                 dv_cur  [0:DW-1];
   logic                 dpos_cur[0:DW-1];
   logic [DW-1:0]        dd_cur  [0:DW-1];
   lane_mask_type        dneg_cur[0:DW-1];
   lane_mask_type        dovf_cur[0:DW-1];
   logic [DW-1:0]        drem_cur[0:DW-1][0:LANES-1];
   logic [DW-1:0]        dlow_cur[0:DW-1][0:LANES-1];
   logic [DW-1:0]        dq_cur  [0:DW-1][0:LANES-1];
   logic [DW:0]          dr2     [0:DW-1][0:LANES-1];
   logic [DW-1:0]        drem_in [0:DW-1][0:LANES-1];
   logic [DW-1:0]        dq_in   [0:DW-1][0:LANES-1];

   always_comb begin
      dv_cur[0]   = uv_ff;
      dpos_cur[0] = upos_ff;
      dd_cur[0]   = ud_ff;
      dneg_cur[0] = uneg_ff;
      dovf_cur[0] = uovf_ff;
      for (int l = 0; l < LANES; l++) begin
         drem_cur[0][l] = urem_ff[l];
         dlow_cur[0][l] = ulow_ff[l];
         dq_cur[0][l]   = '0;
      end
      for (int k = 1; k < DW; k++) begin
         dv_cur[k]   = dv_ff[k-1];
         dpos_cur[k] = dpos_ff[k-1];
         dd_cur[k]   = dd_ff[k-1];
         dneg_cur[k] = dneg_ff[k-1];
         dovf_cur[k] = dovf_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            drem_cur[k][l] = drem_ff[k-1][l];
            dlow_cur[k][l] = dlow_ff[k-1][l];
            dq_cur[k][l]   = dq_ff[k-1][l];
         end
      end
      for (int k = 0; k < DW; k++) begin
         for (int l = 0; l < LANES; l++) begin
            dr2[k][l] = {drem_cur[k][l], dlow_cur[k][l][DW-1]};
            if (dr2[k][l] >= {1'b0, dd_cur[k]}) begin
               drem_in[k][l] = DW'(dr2[k][l] - {1'b0, dd_cur[k]});
               dq_in[k][l]   = {dq_cur[k][l][DW-2:0], 1'b1};
            end else begin
               drem_in[k][l] = dr2[k][l][DW-1:0];
               dq_in[k][l]   = {dq_cur[k][l][DW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DW; k++) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else begin
            dv_ff[k] <= dv_cur[k];
         end
         dpos_ff[k] <= dpos_cur[k];
         dd_ff[k]   <= dd_cur[k];
         dneg_ff[k] <= dneg_cur[k];
         dovf_ff[k] <= dovf_cur[k];
         for (int l = 0; l < LANES; l++) begin
            drem_ff[k][l] <= drem_in[k][l];
            dlow_ff[k][l] <= dlow_cur[k][l] << 1;
            dq_ff[k][l]   <= dq_in[k][l];
         end
      end
   end

   // round is folded into the numerator; saturate and drive the beat
   localparam logic [DW-1:0] QMAX_MAG = DW'((1 << (W-1)) - 1);
   localparam logic [DW-1:0] QMIN_MAG = DW'(1 << (W-1));

   logic [W-1:0] o_in [0:LANES-1];
   logic [W-1:0] o_ff [0:LANES-1];
   logic         ostb_ff, ovres_ff;
   logic [DW-1:0] oq   [0:LANES-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         oq[l] = dq_ff[DW-1][l];
         if (!dpos_ff[DW-1]) begin
            o_in[l] = '0;
         end else if (dneg_ff[DW-1][l]) begin
            if (dovf_ff[DW-1][l] || oq[l] > QMIN_MAG) begin
               o_in[l] = {1'b1, {(W-1){1'b0}}};
            end else begin
               o_in[l] = W'(-oq[l]);
            end
         end else begin
            if (dovf_ff[DW-1][l] || oq[l] > QMAX_MAG) begin
               o_in[l] = {1'b0, {(W-1){1'b1}}};
            end else begin
               o_in[l] = oq[l][W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ostb_ff <= 1'b0;
      end else begin
         ostb_ff <= dv_ff[DW-1];
      end
      ovres_ff <= dpos_ff[DW-1];
      for (int l = 0; l < LANES; l++) begin
         o_ff[l] <= o_in[l];
      end
   end

   assign rsp_strobe    = ostb_ff;
   assign rsp_valid_res = ovres_ff;
   assign rsp_qx        = o_ff[LANE_X];
   assign rsp_qy        = o_ff[LANE_Y];
   assign rsp_qz        = o_ff[LANE_Z];
   assign rsp_qw        = o_ff[LANE_W];

endmodule
`default_nettype wire

[verif/tb_rotation_matrix_to_quaternion_top.sv]
module tb_rotation_matrix_to_quaternion_top;
   localparam int WB = 16;
   localparam int FB = WB - 2;
   localparam int LATENCY = 2 * WB + 4;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic signed [WB-1:0] m [9];
   } matrix_t;

   typedef struct {
      logic signed [WB-1:0] q [4];
      logic                 ok;
   } quat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [WB-1:0] req_r [9];
   logic rsp_strobe, rsp_valid_res;
   logic signed [WB-1:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw;

   matrix_t pending_mats [$];
   quat_t   expected_quats [$];
   int      errors = 0;
   int      beats_in = 0;
   int      beats_out = 0;
   int      invalid_seen = 0;
   int      idle_cycles = 0;
   int      gap = 0;
   bit      stim_done = 0;

   initial begin
      foreach (req_r[i]) req_r[i] = '0;
   end

   rotation_matrix_to_quaternion_top #(.WORD_BITS(WB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_r00(req_r[0]), .req_r01(req_r[1]), .req_r02(req_r[2]),
      .req_r10(req_r[3]), .req_r11(req_r[4]), .req_r12(req_r[5]),
      .req_r20(req_r[6]), .req_r21(req_r[7]), .req_r22(req_r[8]),
      .rsp_strobe(rsp_strobe), .rsp_qx(rsp_qx), .rsp_qy(rsp_qy),
      .rsp_qz(rsp_qz), .rsp_qw(rsp_qw), .rsp_valid_res(rsp_valid_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint root_floor(longint n);
      longint lo, hi, mid;
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= n) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic logic signed [WB-1:0] scale_round_sat(longint v, longint s);
      longint mag, q, lim_pos, lim_neg;
      lim_pos = (longint'(1) << (WB - 1)) - 1;
      lim_neg = longint'(1) << (WB - 1);
      mag = (v < 0) ? -v : v;
      q = ((mag << FB) + s) / (2 * s);
      if (v < 0) return (q > lim_neg) ? WB'(-lim_neg) : WB'(-q);
      return (q > lim_pos) ? WB'(lim_pos) : WB'(q);
   endfunction

   function automatic quat_t matrix_to_quat(matrix_t mt);
      quat_t res;
      longint e [9];
      longint one, t, s;
      longint c [4];
      one = longint'(1) << FB;
      foreach (e[i]) e[i] = mt.m[i];
      if (e[8] < 0) begin
         if (e[0] > e[4]) begin
            t = one + e[0] - e[4] - e[8];
            c[0] = t; c[1] = e[1] + e[3]; c[2] = e[6] + e[2]; c[3] = e[5] - e[7];
         end else begin
            t = one - e[0] + e[4] - e[8];
            c[0] = e[1] + e[3]; c[1] = t; c[2] = e[5] + e[7]; c[3] = e[6] - e[2];
         end
      end else if (e[0] + e[4] < 0) begin
         t = one - e[0] - e[4] + e[8];
         c[0] = e[6] + e[2]; c[1] = e[5] - e[7]; c[2] = t; c[3] = e[1] + e[3];
      end else begin
         t = one + e[0] + e[4] + e[8];
         c[0] = e[5] - e[7]; c[1] = e[6] + e[2]; c[2] = e[1] + e[3]; c[3] = t;
      end
      if (t <= 0) begin
         foreach (res.q[k]) res.q[k] = '0;
         res.ok = 1'b0;
      end else begin
         s = root_floor(t << FB);
         foreach (res.q[k]) res.q[k] = scale_round_sat(c[k], s);
         res.ok = 1'b1;
      end
      return res;
   endfunction

   function automatic logic signed [WB-1:0] rand_elem(int mode);
      case (mode)
         0: return WB'($urandom);
         1: return $urandom_range(0, 1) ? (WB)'(-32768) : (WB)'(32767);
         default: return WB'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // Build a proper rotation from a random unit quaternion, plus small jitter.
   function automatic matrix_t random_rotation();
      matrix_t mt;
      real a, b, c, d, n, r [9];
      a = $urandom_range(0, 2000) - 1000.0;
      b = $urandom_range(0, 2000) - 1000.0;
      c = $urandom_range(0, 2000) - 1000.0;
      d = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
         a = 1.0; n = 1.0;
      end
      a /= n; b /= n; c /= n; d /= n;
      r[0] = 1 - 2 * (c * c + d * d); r[1] = 2 * (b * c - a * d); r[2] = 2 * (b * d + a * c);
      r[3] = 2 * (b * c + a * d); r[4] = 1 - 2 * (b * b + d * d); r[5] = 2 * (c * d - a * b);
      r[6] = 2 * (b * d - a * c); r[7] = 2 * (c * d + a * b); r[8] = 1 - 2 * (b * b + c * c);
      foreach (mt.m[i])
         mt.m[i] = WB'($rtoi(r[i] * 16384.0) + $signed($urandom_range(0, 8)) - 4);
      return mt;
   endfunction

   task automatic push_fill(logic signed [WB-1:0] v);
      matrix_t mt;
      foreach (mt.m[i]) mt.m[i] = v;
      pending_mats.push_back(mt);
   endtask

   task automatic push_diag(int a, int b, int c);
      matrix_t mt;
      foreach (mt.m[i]) mt.m[i] = '0;
      mt.m[0] = WB'(a); mt.m[4] = WB'(b); mt.m[8] = WB'(c);
      pending_mats.push_back(mt);
   endtask

   initial begin
      matrix_t mt;
      int mode;
      push_diag(16384, 16384, 16384);
      push_diag(16384, -16384, -16384);
      push_diag(-16384, 16384, -16384);
      push_diag(-16384, -16384, 16384);
      push_diag(0, 0, -1);
      push_diag(100, 100, -1);
      push_diag(0, -1, 0);
      push_diag(32767, -32768, -32768);
      push_diag(-32768, 32767, -32768);
      push_diag(-32768, -32768, 32767);
      push_diag(32767, 32767, 32767);
      push_diag(-16384, 0, 16383);
      push_diag(32767, 32767, -32768);
      push_fill(16'sh7fff);
      push_fill(16'sh8000);
      push_fill(16'sh0000);
      push_fill(16'shffff);
      push_fill(16'sh5555);
      push_fill(16'shaaaa);
      foreach (mt.m[i]) mt.m[i] = (i % 2) ? 16'sh7fff : 16'sh8000;
      mt.m[0] = 0; mt.m[4] = 0; mt.m[8] = 0;
      pending_mats.push_back(mt);
      for (int n = 0; n < 1500; n++) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) mt = random_rotation();
         else foreach (mt.m[i]) mt.m[i] = rand_elem(mode - 6);
         pending_mats.push_back(mt);
      end
      stim_done = 1;
   end

   task automatic mt_drive();
      matrix_t mt;
      mt = pending_mats.pop_front();
      foreach (req_r[i]) req_r[i] <= mt.m[i];
      start <= 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_quats.push_back(matrix_to_quat(matrix_t'{m: req_r}));
            beats_in++;
         end
         if (start && busy) begin
            // hold the beat
         end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
         end else if (pending_mats.size() > 0) begin
            mt_drive();
            if ($urandom_range(0, 3) == 0)
               gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                 : $urandom_range(1, 3);
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      quat_t exp_q;
      if (!reset && rsp_strobe) begin
         beats_out++;
         if (expected_quats.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            exp_q = expected_quats.pop_front();
            if (!exp_q.ok) invalid_seen++;
            if (rsp_qx !== exp_q.q[0]) begin
               $error("qx expected %0d actual %0d", exp_q.q[0], rsp_qx); errors++;
            end
            if (rsp_qy !== exp_q.q[1]) begin
               $error("qy expected %0d actual %0d", exp_q.q[1], rsp_qy); errors++;
            end
            if (rsp_qz !== exp_q.q[2]) begin
               $error("qz expected %0d actual %0d", exp_q.q[2], rsp_qz); errors++;
            end
            if (rsp_qw !== exp_q.q[3]) begin
               $error("qw expected %0d actual %0d", exp_q.q[3], rsp_qw); errors++;
            end
            if (rsp_valid_res !== exp_q.ok) begin
               $error("valid_res expected %0b actual %0b", exp_q.ok, rsp_valid_res);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_mats.size() == 0 && !start);
      wait (expected_quats.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Ran %0d matrices, %0d results, %0d with no positive pivot.",
               beats_in, beats_out, invalid_seen);
      if (errors == 0 && expected_quats.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

[files.f]
sv/rmq_pkg.sv
sv/rotation_matrix_to_quaternion_top.sv
verif/tb_rotation_matrix_to_quaternion_top.sv
